// ----- rtl/core/lrucd_pkg.sv -----
// Shared types, constants and codes of the LRU chunk cache directory.
package lrucd_pkg;

    localparam int DEF_ENTRIES    = 256;
    localparam int DEF_COORD_BITS = 22;
    localparam int LIMIT_RESET    = 200;
    localparam int LIMIT_BITS     = 9;
    localparam int OUTCOME_BITS   = 3;
    localparam int SLOT_FIELD     = 8;
    localparam int COUNT_FIELD    = 9;

    typedef enum logic [OUTCOME_BITS-1:0] {
        OUT_HIT      = 3'd0,
        OUT_LOADED   = 3'd1,
        OUT_ABSENT   = 3'd2,
        OUT_LOADFAIL = 3'd3,
        OUT_CLEARED  = 3'd4
    } outcome_t;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,      // capture the input item, reset the scan pointer
        CMD_SCAN,       // examine one slot for a key match / free slot
        CMD_CLEAR,      // drop every entry
        CMD_HIT_MOVE,   // start moving the hit slot to the newest end
        CMD_EVICT,      // start unlinking the oldest slot
        CMD_FREE_SCAN,  // restart the scan looking for a free slot
        CMD_INSERT,     // write the key into the free slot and append it
        CMD_LINK_STEP,  // carry out one pending link-memory write
        CMD_RESULT      // form the result item
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic      fail;  // the load failed: the free scan sets OUT_LOADFAIL
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;  // scan stopped: match or free slot found, or all slots seen
        logic hit;
        logic is_clear;
        logic present;
        logic load_ok;
        logic need_evict;
        logic is_newest;
        logic link_busy;  // link writes still pending
    } dp_status_t;

endpackage

// ----- rtl/core/lrucd_datapath.sv -----
// Datapath of the LRU chunk cache directory: key store, links and result.
module lrucd_datapath
    import lrucd_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic [LIMIT_BITS-1:0]     limit,
    input  logic                      in_action,
    input  logic [COORD_BITS-1:0]     in_x,
    input  logic [COORD_BITS-1:0]     in_y,
    input  logic                      in_present,
    input  logic                      in_load_ok,
    output logic [OUTCOME_BITS-1:0]   res_outcome,
    output logic [SLOT_FIELD-1:0]     res_slot,
    output logic                      res_evicted,
    output logic [COORD_BITS-1:0]     res_ev_x,
    output logic [COORD_BITS-1:0]     res_ev_y,
    output logic [COUNT_FIELD-1:0]    res_cleared
);
    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = 2 * COORD_BITS;

    logic [ENTRIES-1:0] valid_reg;
    logic [KW-1:0]      key_mem [ENTRIES];
    logic [SW-1:0]      nxt_mem [ENTRIES];
    logic [SW-1:0]      prv_mem [ENTRIES];

    logic [SW-1:0] oldest_reg, newest_reg;
    logic [CW-1:0] count_reg;
    logic [KW-1:0] key_reg;
    logic act_reg, pres_reg, ok_reg;
    logic [CW-1:0] ptr_reg;       // scan pointer, wide enough to hold ENTRIES
    logic hit_reg, free_mode_reg;
    logic [SW-1:0] hit_slot_reg, free_slot_reg;
    logic [KW-1:0] rd_key_reg;
    logic [SW-1:0] rd_nxt_reg, rd_prv_reg;
    logic [SW-1:0] rd_slot_reg;
    logic rd_valid_reg, rd_pend_reg;
    logic ev_reg;
    logic [KW-1:0] evkey_reg;
    logic [CW-1:0] cleared_reg;
    outcome_t outcome_reg;

    // Link writes pending after an unlink/append, done one per cycle.
    logic [2:0]    lk_phase_reg;
    logic [SW-1:0] lk_slot_reg;    // slot being unlinked
    logic          lk_append_reg;  // append lk_slot after the unlink
    logic          lk_unlink_reg;

    logic [CW-1:0] lim_eff;
    always_comb begin
        if (limit == '0) lim_eff = CW'(1);
        else if (32'(limit) > ENTRIES) lim_eff = CW'(ENTRIES);
        else lim_eff = CW'(limit);
    end

    // One registered read of the stores per cycle, at the scan pointer
    // or at the slot whose links are being fixed up.
    logic [SW-1:0] rd_addr;
    logic          rd_en;
    assign rd_addr = (lk_phase_reg == 3'd1) ? lk_slot_reg : ptr_reg[SW-1:0];
    assign rd_en   = (cmd.code == CMD_SCAN) || (lk_phase_reg == 3'd1);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_nxt_reg  <= nxt_mem[rd_addr];
            rd_prv_reg  <= prv_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            rd_slot_reg <= rd_addr;
        end
    end

    logic scan_last;
    assign scan_last = (ptr_reg == CW'(ENTRIES));

    // Link memory write port (single write per cycle).
    logic          lw_nxt_en, lw_prv_en;
    logic [SW-1:0] lw_addr, lw_data;
    logic          key_we;
    logic [SW-1:0] key_waddr;

    always_comb begin
        lw_nxt_en = 1'b0;
        lw_prv_en = 1'b0;
        lw_addr   = '0;
        lw_data   = '0;
        key_we    = (cmd.code == CMD_INSERT);
        key_waddr = free_slot_reg;
        if (cmd.code == CMD_LINK_STEP) begin
            unique case (lk_phase_reg)
                3'd2: begin  // predecessor's next <= successor
                    if (lk_unlink_reg && lk_slot_reg != oldest_reg) begin
                        lw_nxt_en = 1'b1;
                        lw_addr   = rd_prv_reg;
                        lw_data   = rd_nxt_reg;
                    end
                end
                3'd3: begin  // successor's prev <= predecessor
                    if (lk_unlink_reg && lk_slot_reg != newest_reg) begin
                        lw_prv_en = 1'b1;
                        lw_addr   = rd_nxt_reg;
                        lw_data   = rd_prv_reg;
                    end
                end
                3'd4: begin  // newest's next <= slot
                    if (lk_append_reg && count_reg != '0) begin
                        lw_nxt_en = 1'b1;
                        lw_addr   = newest_reg;
                        lw_data   = lk_slot_reg;
                    end
                end
                3'd5: begin  // slot's prev <= newest
                    if (lk_append_reg && count_reg != '0) begin
                        lw_prv_en = 1'b1;
                        lw_addr   = lk_slot_reg;
                        lw_data   = newest_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (lw_nxt_en) nxt_mem[lw_addr] <= lw_data;
        if (lw_prv_en) prv_mem[lw_addr] <= lw_data;
        if (key_we)    key_mem[key_waddr] <= key_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            hit_reg       <= 1'b0;
            free_mode_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            lk_phase_reg  <= '0;
            lk_append_reg <= 1'b0;
            lk_unlink_reg <= 1'b0;
            ev_reg        <= 1'b0;
        end else begin
            unique case (cmd.code)
                CMD_LATCH: begin
                    key_reg  <= {in_y, in_x};
                    act_reg  <= in_action;
                    pres_reg <= in_present;
                    ok_reg   <= in_load_ok;
                    ptr_reg  <= '0;
                    hit_reg  <= 1'b0;
                    ev_reg   <= 1'b0;
                    evkey_reg <= '0;
                    cleared_reg <= '0;
                    free_mode_reg <= 1'b0;
                    rd_pend_reg <= 1'b0;
                    // A miss on an absent chunk keeps this outcome.
                    outcome_reg <= OUT_ABSENT;
                end
                CMD_SCAN: begin
                    // Check the previous read while issuing the next one.
                    if (!scan_last) ptr_reg <= ptr_reg + CW'(1);
                    rd_pend_reg <= !scan_last;
                    if (rd_pend_reg) begin
                        if (!free_mode_reg && rd_valid_reg && rd_key_reg == key_reg) begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= rd_slot_reg;
                        end
                        if (free_mode_reg && !rd_valid_reg) begin
                            hit_reg       <= 1'b1;
                            free_slot_reg <= rd_slot_reg;
                        end
                    end
                end
                CMD_CLEAR: begin
                    cleared_reg <= count_reg;
                    valid_reg   <= '0;
                    count_reg   <= '0;
                    oldest_reg  <= '0;
                    newest_reg  <= '0;
                    outcome_reg <= OUT_CLEARED;
                end
                CMD_HIT_MOVE: begin
                    lk_slot_reg   <= hit_slot_reg;
                    lk_unlink_reg <= 1'b1;
                    lk_append_reg <= 1'b1;
                    // An entry that is already the newest stays where it is.
                    lk_phase_reg  <= (hit_slot_reg == newest_reg) ? 3'd0 : 3'd1;
                    outcome_reg   <= OUT_HIT;
                end
                CMD_EVICT: begin
                    ev_reg        <= 1'b1;
                    lk_slot_reg   <= oldest_reg;
                    lk_unlink_reg <= 1'b1;
                    lk_append_reg <= 1'b0;
                    lk_phase_reg  <= 3'd1;
                end
                CMD_FREE_SCAN: begin
                    ptr_reg       <= '0;
                    hit_reg       <= 1'b0;
                    free_mode_reg <= 1'b1;
                    rd_pend_reg   <= 1'b0;
                    outcome_reg   <= cmd.fail ? OUT_LOADFAIL : OUT_LOADED;
                end
                CMD_INSERT: begin
                    valid_reg[free_slot_reg] <= 1'b1;
                    hit_slot_reg  <= free_slot_reg;
                    lk_slot_reg   <= free_slot_reg;
                    lk_unlink_reg <= 1'b0;
                    lk_append_reg <= 1'b1;
                    lk_phase_reg  <= 3'd2;
                end
                CMD_LINK_STEP: begin
                    unique case (lk_phase_reg)
                        3'd1: lk_phase_reg <= 3'd2;  // links of slot read
                        3'd2: begin
                            if (ev_reg && !lk_append_reg && lk_slot_reg == rd_slot_reg)
                                evkey_reg <= rd_key_reg;
                            lk_phase_reg <= 3'd3;
                        end
                        3'd3: begin
                            // Update the end pointers of the unlink.
                            if (lk_unlink_reg) begin
                                if (lk_slot_reg == oldest_reg) oldest_reg <= rd_nxt_reg;
                                if (lk_slot_reg == newest_reg) newest_reg <= rd_prv_reg;
                                if (!lk_append_reg) begin
                                    valid_reg[lk_slot_reg] <= 1'b0;
                                    count_reg <= count_reg - CW'(1);
                                    if (count_reg == CW'(1)) begin
                                        oldest_reg <= '0;
                                        newest_reg <= '0;
                                    end
                                end
                            end
                            lk_phase_reg <= lk_append_reg ? 3'd4 : 3'd0;
                        end
                        3'd4: lk_phase_reg <= 3'd5;
                        3'd5: begin
                            if (count_reg == '0 && !lk_unlink_reg) begin
                                oldest_reg <= lk_slot_reg;
                            end
                            newest_reg <= lk_slot_reg;
                            if (!lk_unlink_reg) count_reg <= count_reg + CW'(1);
                            lk_phase_reg <= 3'd0;
                        end
                        default: lk_phase_reg <= 3'd0;
                    endcase
                end
                CMD_RESULT: ;
                default: ;
            endcase
        end
    end

    // Pending read of the slot captured in phase 2 must cover evicted key.
    assign status.scan_done  = hit_reg || (scan_last && !rd_pend_reg);
    assign status.hit        = hit_reg;
    assign status.is_clear   = act_reg;
    assign status.present    = pres_reg;
    assign status.load_ok    = ok_reg;
    assign status.need_evict = (count_reg != '0) && (count_reg >= lim_eff);
    assign status.is_newest  = (hit_slot_reg == newest_reg);
    assign status.link_busy  = (lk_phase_reg != 3'd0);

    assign res_outcome = outcome_reg;
    assign res_slot    = (outcome_reg == OUT_HIT || outcome_reg == OUT_LOADED) ?
                         SLOT_FIELD'(hit_slot_reg) : '0;
    assign res_evicted = ev_reg;
    assign res_ev_x    = evkey_reg[COORD_BITS-1:0];
    assign res_ev_y    = evkey_reg[KW-1:COORD_BITS];
    assign res_cleared = (outcome_reg == OUT_CLEARED) ? COUNT_FIELD'(cleared_reg) : '0;

endmodule

// ----- rtl/core/lrucd_ctrl.sv -----
// Controller state machine of the LRU chunk cache directory.
module lrucd_ctrl
    import lrucd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_load,
    input  logic       out_free,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_DECIDE = 10'b0000000010,
        ST_SCAN   = 10'b0000000100,
        ST_MISS   = 10'b0000001000,
        ST_EVLINK = 10'b0000010000,
        ST_FREE   = 10'b0000100000,
        ST_INSERT = 10'b0001000000,
        ST_LINK   = 10'b0010000000,
        ST_RESULT = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.code   = CMD_NONE;
        cmd.fail   = !status.load_ok;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (in_valid) begin
                cmd.code   = CMD_LATCH;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (status.is_clear) begin
                    cmd.code   = CMD_CLEAR;
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    if (status.hit) begin
                        if (status.is_newest) begin
                            cmd.code = CMD_HIT_MOVE;
                            state_next = ST_RESULT;
                        end else begin
                            cmd.code = CMD_HIT_MOVE;
                            state_next = ST_LINK;
                        end
                    end else begin
                        state_next = ST_MISS;
                    end
                end else begin
                    cmd.code = CMD_SCAN;
                end
            end
            ST_MISS: begin
                if (!status.present) state_next = ST_RESULT;
                else if (status.need_evict) begin
                    cmd.code   = CMD_EVICT;
                    state_next = ST_EVLINK;
                end else begin
                    cmd.code   = CMD_FREE_SCAN;
                    state_next = status.load_ok ? ST_FREE : ST_RESULT;
                end
            end
            ST_EVLINK: begin
                if (status.link_busy) cmd.code = CMD_LINK_STEP;
                else begin
                    cmd.code   = CMD_FREE_SCAN;
                    state_next = status.load_ok ? ST_FREE : ST_RESULT;
                end
            end
            ST_FREE: begin
                if (status.scan_done) state_next = ST_INSERT;
                else cmd.code = CMD_SCAN;
            end
            ST_INSERT: begin
                cmd.code   = CMD_INSERT;
                state_next = ST_LINK;
            end
            ST_LINK: begin
                if (status.link_busy) cmd.code = CMD_LINK_STEP;
                else state_next = ST_RESULT;
            end
            ST_RESULT: begin
                cmd.code   = CMD_RESULT;
                state_next = ST_OUT;
            end
            ST_OUT: if (out_free) begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ----- rtl/core/lru_chunk_cache_directory.sv -----
// Top level of the LRU chunk cache directory.
// A fully associative directory of up to ENTRIES chunk keys kept in
// least-recently-used order by a doubly linked list over the slots. Each
// s_ transfer is one action: a lookup, or a clear that drops every entry.
// A lookup scans the key store one slot per cycle to find a hit or confirm
// a miss; a successful load then scans again for a free slot, and the
// links are updated to move a hit, unlink an evicted entry or append an
// insert. One item is handled at a time; the finished result is loaded
// into an output register once that register is free, and the next item
// is taken after that, while the m_ side may still hold the result. The
// user must write capacity_limit over the cfg channel only while idle;
// the block does not enforce this. Zero acts as one, and values above
// ENTRIES act as ENTRIES. No clearing pass is needed after reset.
module lru_chunk_cache_directory
    import lrucd_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,    // [8:0] capacity_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] action, [1+:CB] chunk_x, [1+CB+:CB] chunk_y,
    // [1+2CB] region_present, [2+2CB] load_ok, zero filled to bytes
    input  logic [((2*COORD_BITS+3+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] outcome, [10:3] slot, [11] evicted, [12+:CB] evicted_x,
    // [12+CB+:CB] evicted_y, [12+2CB+:9] cleared_count, zero filled
    output logic [((2*COORD_BITS+21+7)/8)*8-1:0] m_tdata
);
    localparam int CB = COORD_BITS;
    localparam int OW = ((2*COORD_BITS+21+7)/8)*8;

    logic [LIMIT_BITS-1:0] limit_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) limit_reg <= LIMIT_BITS'(LIMIT_RESET);
        else if (cfg_valid) limit_reg <= cfg_data[LIMIT_BITS-1:0];
    end

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       out_load;
    logic [OUTCOME_BITS-1:0] r_outcome;
    logic [SLOT_FIELD-1:0]   r_slot;
    logic                    r_ev;
    logic [CB-1:0]           r_ex, r_ey;
    logic [COUNT_FIELD-1:0]  r_cl;

    lrucd_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_load (out_load),
        .out_free (!m_tvalid || m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lrucd_datapath #(.ENTRIES(ENTRIES), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .status,
        .limit       (limit_reg),
        .in_action   (s_tdata[0]),
        .in_x        (s_tdata[1 +: CB]),
        .in_y        (s_tdata[1+CB +: CB]),
        .in_present  (s_tdata[1+2*CB]),
        .in_load_ok  (s_tdata[2+2*CB]),
        .res_outcome (r_outcome),
        .res_slot    (r_slot),
        .res_evicted (r_ev),
        .res_ev_x    (r_ex),
        .res_ev_y    (r_ey),
        .res_cleared (r_cl)
    );

    // Output register: holds a result until the m_ side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (out_load) m_tdata <= OW'({r_cl, r_ey, r_ex, r_ev, r_slot, r_outcome});
    end

endmodule

// ----- rtl/core/lrucd_checker.sv -----
// Port-level checker of the LRU chunk cache directory, bound to the top.
module lrucd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [2:0] m_outcome,
    input logic       m_evicted
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second item taken");
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_outcome <= 3'd4) else $error("bad outcome");
    a_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_evicted |-> (m_outcome == 3'd1 || m_outcome == 3'd3))
        else $error("eviction on wrong outcome");
endmodule

bind lru_chunk_cache_directory lrucd_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
    .m_outcome (m_tdata[2:0]),
    .m_evicted (m_tdata[11])
);
